// ===== rtl/core/bcs_pkg.sv =====
package bcs_pkg;

    // action carried with every pressure sample
    typedef enum logic [1:0] {
        ACT_SAT    = 2'd0,
        ACT_DERIV1 = 2'd1,
        ACT_DERIV2 = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RES_LIQUID = 2'd0,
        CFG_RES_GAS    = 2'd1,
        CFG_PORE_EXP   = 2'd2,
        CFG_ENTRY_PRES = 2'd3
    } t_cfg_idx;

    // internal binary exponent
    localparam int EXP_W = 12;
    typedef logic signed [EXP_W-1:0] t_exp;

    // floor square root of a 64-bit value
    function automatic logic [31:0] isqrt64(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if ((64'(t) * 64'(t)) <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // 2^-(2^-i) in Q1.31, each one the square root of the previous, from 0.5
    function automatic logic [31:0] exp2_root(input int i);
        logic [63:0] c;
        c = 64'd1 << 30;
        for (int k = 1; k <= i; k++) begin
            c = {32'd0, isqrt64(c << 31)};
        end
        return c[31:0];
    endfunction

endpackage

// ===== rtl/core/brooks_corey_saturation_top.sv =====
// Brooks-Corey saturation curve. Each transaction on the slave stream carries a
// capillary pressure in pascals and an action (saturation, dS/dp or d2S/dp2);
// the master stream returns one result per transaction as a Q1.30 mantissa with
// a binary exponent, plus a status flag that is set when the saturation span
// (1 - residual gas - residual liquid) is not positive. The datapath is one
// long pipeline: a squaring log2 unit (FRAC_BITS stages), a root-product exp2
// unit (FRAC_BITS stages), two restoring dividers of 64 stages each and a short
// normalize tail. A new transaction is taken every cycle while the skid
// register is empty. A skid register at the output lets the pipe absorb one
// held result before it stops taking input. Configuration must be written
// through the cfg port only while no transaction is in flight; the block
// itself does not enforce this.
module brooks_corey_saturation_top
    import bcs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] pressure_pa
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] result_mantissa, [40:32] result_exponent
    output logic [0:0]  m_axis_tuser    // [0] status
);

    localparam int LW  = FRAC_BITS + 5;   // log2 result width
    localparam int DW  = FRAC_BITS + 9;   // scaled exponent width
    localparam int NST = 2 * FRAC_BITS + 142;

    typedef struct packed {
        t_action     act;
        logic        le;
        logic [31:0] pe;
    } t_base;

    typedef struct packed {
        t_base         b;
        logic [32:0]   lam2;
        logic [31:0]   ya;
        logic [31:0]   yb;
        logic [LW-1:0] la;
        logic [LW-1:0] lb;
    } t_lg;

    typedef struct packed {
        t_base                b;
        logic [32:0]          lam2;
        logic [8:0]           n;
        logic [FRAC_BITS-1:0] f;
        logic                 gz;
        logic [31:0]          acc;
    } t_ex;

    typedef struct packed {
        t_base       b;
        logic [31:0] g;
        logic [8:0]  n;
        logic [63:0] z;
        logic [31:0] rem;
        t_exp        te;
        logic        zero;
        logic [5:0]  sh;
        logic        byp;
    } t_dv;

    typedef struct packed {
        t_base       b;
        logic [8:0]  n;
        t_exp        te;
        logic        zero;
        logic [63:0] z;
        logic [5:0]  sh;
        logic [47:0] prod;
    } t_f1;

    typedef struct packed {
        t_base       b;
        t_exp        te;
        logic        zero;
        logic [31:0] t32;
        logic [47:0] term;
    } t_f2;

    typedef struct packed {
        t_base       b;
        logic        zero;
        logic [48:0] rm;
        t_exp        re;
        logic [48:0] smag;
        logic        sneg;
    } t_f3;

    typedef struct packed {
        logic [48:0] m;
        t_exp        e;
        logic        neg;
        logic        zz;
        logic [5:0]  j;
    } t_f4;

    typedef struct packed {
        logic [31:0] mant;
        logic [8:0]  expo;
        logic        stat;
    } t_res;

    function automatic logic [5:0] msb64(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 64; k++) begin
            if (v[k]) begin
                r = 6'(k);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [15:0] r_res_liq;
    logic [15:0] r_res_gas;
    logic [15:0] r_pore_exp;
    logic [31:0] r_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_liq  <= 16'd0;
            r_res_gas  <= 16'd0;
            r_pore_exp <= 16'd8192;
            r_entry    <= 32'd1000;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RES_LIQUID: r_res_liq  <= i_cfg_data[15:0];
                CFG_RES_GAS:    r_res_gas  <= i_cfg_data[15:0];
                CFG_PORE_EXP:   r_pore_exp <= i_cfg_data[15:0];
                CFG_ENTRY_PRES: r_entry    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived from config; the user must keep it static while transactions are in flight, the block does not enforce it
    logic [16:0]        w_smax;
    logic signed [17:0] w_span;
    logic signed [17:0] w_span_abs;
    logic [16:0]        w_aspan;
    logic               w_span_neg;
    logic               w_span_pos;

    assign w_smax     = 17'h10000 - {1'b0, r_res_gas};
    assign w_span     = $signed({1'b0, w_smax}) - $signed({2'b00, r_res_liq});
    assign w_span_neg = w_span[17];
    assign w_span_pos = !w_span[17] && (w_span != 18'sd0);
    assign w_span_abs = w_span_neg ? -w_span : w_span;
    assign w_aspan    = w_span_abs[16:0];

    // ---------------------------------------------------------------------
    // pipeline control: every stage moves when the skid register is free
    // ---------------------------------------------------------------------
    logic             w_en;
    logic [NST-1:0]   r_vld;
    t_res             r_out;
    logic             r_out_vld;
    t_res             r_skid;
    logic             r_skid_vld;
    t_res             r_f5;

    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage a: input capture
    logic [31:0] r_a_p;
    t_action     r_a_act;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_p   <= s_axis_tdata;
            r_a_act <= t_action'(s_axis_tuser);
        end
    end

    // stage b: clamp pressure to the entry pressure
    t_base r_b;
    logic  w_le;

    assign w_le = $signed({r_a_p[31], r_a_p}) <= $signed({1'b0, r_entry});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b.act <= r_a_act;
            r_b.le  <= w_le;
            r_b.pe  <= w_le ? r_entry : r_a_p;
        end
    end

    // ---------------------------------------------------------------------
    // log2 of clamped pressure and entry pressure, one fraction bit a stage
    // ---------------------------------------------------------------------
    t_lg r_lg [0:FRAC_BITS];
    t_lg n_lg0;
    logic [5:0] w_ka;
    logic [5:0] w_kb;

    always_comb begin
        w_ka          = msb64({32'd0, r_b.pe});
        w_kb          = msb64({32'd0, r_entry});
        n_lg0.b       = r_b;
        n_lg0.lam2    = 33'(r_pore_exp) * 33'(17'(r_pore_exp) + 17'd4096);
        n_lg0.ya      = r_b.pe << (6'd31 - w_ka);
        n_lg0.yb      = r_entry << (6'd31 - w_kb);
        n_lg0.la      = {w_ka[4:0], {FRAC_BITS{1'b0}}};
        n_lg0.lb      = {w_kb[4:0], {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lg[0] <= n_lg0;
        end
    end

    for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_log
        t_lg         n_lg;
        logic [63:0] w_sqa;
        logic [63:0] w_sqb;

        always_comb begin
            n_lg  = r_lg[i-1];
            w_sqa = 64'(r_lg[i-1].ya) * 64'(r_lg[i-1].ya);
            w_sqb = 64'(r_lg[i-1].yb) * 64'(r_lg[i-1].yb);
            if (w_sqa[63]) begin
                n_lg.ya               = w_sqa[63:32];
                n_lg.la[FRAC_BITS-i]  = 1'b1;
            end else begin
                n_lg.ya = w_sqa[62:31];
            end
            if (w_sqb[63]) begin
                n_lg.yb               = w_sqb[63:32];
                n_lg.lb[FRAC_BITS-i]  = 1'b1;
            end else begin
                n_lg.yb = w_sqb[62:31];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lg[i] <= n_lg;
            end
        end
    end

    // ---------------------------------------------------------------------
    // scaled exponent d = lambda * (log2 pe - log2 entry), split into n and f
    // ---------------------------------------------------------------------
    t_ex r_ex [0:FRAC_BITS];
    t_ex n_ex0;
    logic [LW:0]      w_diff;
    logic [LW-1:0]    w_dcl;
    logic [LW+15:0]   w_dprod;
    logic [DW-1:0]    w_d;
    logic             w_gz;

    always_comb begin
        w_diff  = {1'b0, r_lg[FRAC_BITS].la} - {1'b0, r_lg[FRAC_BITS].lb};
        w_dcl   = w_diff[LW] ? '0 : w_diff[LW-1:0];
        w_dprod = (LW+16)'(r_pore_exp) * (LW+16)'(w_dcl);
        w_gz    = (r_entry == 32'd0) && (r_pore_exp != 16'd0);
        w_d     = ((r_pore_exp == 16'd0) || w_gz) ? '0 : w_dprod[LW+15:12];
        n_ex0.b    = r_lg[FRAC_BITS].b;
        n_ex0.lam2 = r_lg[FRAC_BITS].lam2;
        n_ex0.n    = w_d[DW-1:FRAC_BITS];
        n_ex0.f    = w_d[FRAC_BITS-1:0];
        n_ex0.gz   = w_gz;
        n_ex0.acc  = 32'h8000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ex[0] <= n_ex0;
        end
    end

    // 2^-f as a product of root constants, one fraction bit a stage
    for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_exp
        localparam logic [31:0] ROOT = exp2_root(i);
        t_ex         n_ex;
        logic [63:0] w_pr;

        always_comb begin
            n_ex = r_ex[i-1];
            w_pr = 64'(r_ex[i-1].acc) * 64'(ROOT);
            if (r_ex[i-1].f[FRAC_BITS-i]) begin
                n_ex.acc = w_pr[62:31];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ex[i] <= n_ex;
            end
        end
    end

    // ---------------------------------------------------------------------
    // stage t: lambda term times s_eff
    // ---------------------------------------------------------------------
    t_dv         r_t;
    t_dv         n_t;
    logic [31:0] w_g;
    logic [31:0] w_lamv;
    t_exp        w_elam;

    always_comb begin
        w_g = r_ex[FRAC_BITS].gz ? 32'd0 : r_ex[FRAC_BITS].acc;
        if (r_ex[FRAC_BITS].b.act == ACT_DERIV2) begin
            if (r_ex[FRAC_BITS].lam2[32]) begin
                w_lamv = r_ex[FRAC_BITS].lam2[32:1];
                w_elam = t_exp'(-23);
            end else begin
                w_lamv = r_ex[FRAC_BITS].lam2[31:0];
                w_elam = t_exp'(-24);
            end
        end else begin
            w_lamv = {16'd0, r_pore_exp};
            w_elam = t_exp'(-12);
        end
        n_t.b    = r_ex[FRAC_BITS].b;
        n_t.g    = w_g;
        n_t.n    = r_ex[FRAC_BITS].n;
        n_t.z    = 64'(w_lamv) * 64'(w_g);
        n_t.rem  = '0;
        n_t.te   = w_elam - t_exp'(31) - t_exp'({1'b0, r_ex[FRAC_BITS].n});
        n_t.zero = 1'b0;
        n_t.sh   = '0;
        n_t.byp  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t <= n_t;
        end
    end

    // ---------------------------------------------------------------------
    // first quotient: leading-zero count, left-justify, then divide by pe
    // ---------------------------------------------------------------------
    t_dv r_n1;
    t_dv n_n1;
    t_dv r_q1 [0:64];
    t_dv n_q10;

    always_comb begin
        n_n1      = r_t;
        n_n1.sh   = 6'(6'd63 - msb64(r_t.z));
        n_n1.zero = (r_t.z == 64'd0) || (r_t.b.pe == 32'd0);
    end

    always_comb begin
        n_q10     = r_n1;
        n_q10.z   = r_n1.z << r_n1.sh;
        n_q10.te  = r_n1.te - t_exp'({1'b0, r_n1.sh});
        n_q10.rem = '0;
    end

    // second quotient only for the second derivative, else a pass by rotation
    t_dv r_n3;
    t_dv n_n3;
    t_dv r_q2 [0:64];
    t_dv n_q20;

    always_comb begin
        n_n3     = r_q1[64];
        n_n3.byp = (r_q1[64].b.act != ACT_DERIV2);
        n_n3.sh  = n_n3.byp ? 6'd0 : 6'(6'd63 - msb64(r_q1[64].z));
        if (!n_n3.byp && (r_q1[64].z == 64'd0)) begin
            n_n3.zero = 1'b1;
        end
    end

    always_comb begin
        n_q20     = r_n3;
        n_q20.z   = r_n3.z << r_n3.sh;
        n_q20.te  = r_n3.te - t_exp'({1'b0, r_n3.sh});
        n_q20.rem = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1    <= n_n1;
            r_q1[0] <= n_q10;
            r_n3    <= n_n3;
            r_q2[0] <= n_q20;
        end
    end

    // restoring divider stages, one quotient bit each
    for (genvar i = 1; i <= 64; i++) begin : g_div
        t_dv         n_q1;
        t_dv         n_q2;
        logic [32:0] w_tmp1;
        logic [32:0] w_dif1;
        logic        w_ge1;
        logic [32:0] w_tmp2;
        logic [32:0] w_dif2;
        logic        w_ge2;

        always_comb begin
            n_q1   = r_q1[i-1];
            w_tmp1 = {r_q1[i-1].rem, r_q1[i-1].z[63]};
            w_dif1 = w_tmp1 - {1'b0, r_q1[i-1].b.pe};
            w_ge1  = (w_tmp1 >= {1'b0, r_q1[i-1].b.pe});
            n_q1.rem = w_ge1 ? w_dif1[31:0] : w_tmp1[31:0];
            n_q1.z   = {r_q1[i-1].z[62:0], w_ge1};
        end

        always_comb begin
            n_q2   = r_q2[i-1];
            w_tmp2 = {r_q2[i-1].rem, r_q2[i-1].z[63]};
            w_dif2 = w_tmp2 - {1'b0, r_q2[i-1].b.pe};
            w_ge2  = (w_tmp2 >= {1'b0, r_q2[i-1].b.pe});
            if (r_q2[i-1].byp) begin
                n_q2.z = {r_q2[i-1].z[62:0], r_q2[i-1].z[63]};
            end else begin
                n_q2.rem = w_ge2 ? w_dif2[31:0] : w_tmp2[31:0];
                n_q2.z   = {r_q2[i-1].z[62:0], w_ge2};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_q1[i] <= n_q1;
                r_q2[i] <= n_q2;
            end
        end
    end

    // ---------------------------------------------------------------------
    // tail: narrow the quotient, times span; saturation term alongside
    // ---------------------------------------------------------------------
    t_f1        r_f1;
    t_f1        n_f1;
    logic [5:0] w_h;

    always_comb begin
        w_h       = msb64(r_q2[64].z);
        n_f1.b    = r_q2[64].b;
        n_f1.n    = r_q2[64].n;
        n_f1.te   = r_q2[64].te;
        n_f1.zero = r_q2[64].zero;
        n_f1.z    = r_q2[64].z;
        n_f1.sh   = (w_h > 6'd31) ? 6'(w_h - 6'd31) : 6'd0;
        n_f1.prod = 48'(r_q2[64].g) * 48'(w_aspan);
    end

    t_f2         r_f2;
    t_f2         n_f2;
    logic [63:0] w_zs;

    always_comb begin
        w_zs      = r_f1.z >> r_f1.sh;
        n_f2.b    = r_f1.b;
        n_f2.te   = r_f1.te + t_exp'({1'b0, r_f1.sh});
        n_f2.zero = r_f1.zero;
        n_f2.t32  = w_zs[31:0];
        n_f2.term = (r_f1.n < 9'd64) ? (r_f1.prod >> r_f1.n[5:0]) : 48'd0;
    end

    t_f3                r_f3;
    t_f3                n_f3;
    logic signed [49:0] w_sv;
    logic signed [49:0] w_sabs;
    logic signed [49:0] w_rl;
    logic signed [49:0] w_ts;

    always_comb begin
        w_rl   = $signed({3'b000, r_res_liq, 31'd0});
        w_ts   = $signed({2'b00, r_f2.term});
        w_sv   = w_span_neg ? (w_rl - w_ts) : (w_rl + w_ts);
        w_sabs = w_sv[49] ? -w_sv : w_sv;
        n_f3.b    = r_f2.b;
        n_f3.zero = r_f2.zero;
        n_f3.rm   = 49'(r_f2.t32) * 49'(w_aspan);
        n_f3.re   = r_f2.te - t_exp'(16);
        n_f3.smag = w_sabs[48:0];
        n_f3.sneg = w_sv[49];
    end

    // select the answer for the action, find its leading one
    t_f4 r_f4;
    t_f4 n_f4;

    always_comb begin
        n_f4.m   = '0;
        n_f4.e   = '0;
        n_f4.neg = 1'b0;
        case (r_f3.b.act)
            ACT_SAT: begin
                if (r_f3.b.le) begin
                    n_f4.m = 49'(w_smax);
                    n_f4.e = t_exp'(-16);
                end else begin
                    n_f4.m   = r_f3.smag;
                    n_f4.e   = t_exp'(-47);
                    n_f4.neg = r_f3.sneg;
                end
            end
            ACT_DERIV1: begin
                n_f4.m   = r_f3.zero ? 49'd0 : r_f3.rm;
                n_f4.e   = r_f3.re;
                n_f4.neg = w_span_pos;
            end
            ACT_DERIV2: begin
                n_f4.m   = r_f3.zero ? 49'd0 : r_f3.rm;
                n_f4.e   = r_f3.re;
                n_f4.neg = w_span_neg;
            end
            default: ;
        endcase
        n_f4.zz = (n_f4.m == 49'd0);
        n_f4.j  = msb64({15'd0, n_f4.m});
    end

    // normalize to Q1.30, range limits, sign
    t_res        n_f5;
    t_exp        w_ex;
    logic [48:0] w_msh;
    logic [30:0] w_mn;

    always_comb begin
        w_ex = r_f4.e + t_exp'({1'b0, r_f4.j});
        if (r_f4.j >= 6'd30) begin
            w_msh = r_f4.m >> (r_f4.j - 6'd30);
        end else begin
            w_msh = r_f4.m << (6'd30 - r_f4.j);
        end
        w_mn = w_msh[30:0];
        n_f5.stat = w_span_neg || (w_span == 18'sd0);
        if (r_f4.zz || (w_ex < t_exp'(-160))) begin
            n_f5.mant = '0;
            n_f5.expo = '0;
        end else begin
            if (w_ex > t_exp'(127)) begin
                w_mn = 31'h7FFF_FFFF;
                w_ex = t_exp'(127);
            end
            n_f5.mant = r_f4.neg ? (32'd0 - {1'b0, w_mn}) : {1'b0, w_mn};
            n_f5.expo = w_ex[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1 <= n_f1;
            r_f2 <= n_f2;
            r_f3 <= n_f3;
            r_f4 <= n_f4;
            r_f5 <= n_f5;
        end
    end

    // ---------------------------------------------------------------------
    // output register with skid: a held result never stalls the pipe at once
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_vld[NST-1];
            end
        end else if (w_en && r_vld[NST-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : r_f5;
        end else if (w_en && r_vld[NST-1]) begin
            r_skid <= r_f5;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out.expo, r_out.mant};
    assign m_axis_tuser  = r_out.stat;

endmodule
